@@ sv/lzwe_pkg.sv @@
// Package for the LZW encoder: shared constants, the queue item type and
// the back-end state encoding. No dependencies.
package lzwe_pkg;

    localparam int DICT_ENTRIES_DEFAULT = 4096;
    localparam int FIRST_FREE           = 256;
    localparam int CFG_W                = 13;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 13'd4096;
    localparam int QUEUE_DEPTH          = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
        logic       first;
    } lzwe_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MISS,
        ST_A_LO,
        ST_A_HI,
        ST_TAIL,
        ST_B_LO,
        ST_B_HI
    } lzwe_state_t;

endpackage

@@ sv/lzwe_front.sv @@
// Front end of the LZW encoder: accepts input bytes, marks the first byte of
// each stream and holds them in a short queue. Depends on lzwe_pkg.
module lzwe_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               s_end_of_stream,
    output lzwe_pkg::lzwe_item_t q_item,
    output logic               q_valid,
    input  logic               q_pop
);
    import lzwe_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lzwe_item_t     queue_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           first_reg, first_next;
    logic           push;
    logic           pop;

    assign s_ready = (count_reg < CW'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            first_next  = s_end_of_stream;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            first_reg  <= 1'b1;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= '{in_byte: s_in_byte, end_of_stream: s_end_of_stream,
                                       first: first_reg};
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == CW'(QUEUE_DEPTH)) |-> !push)
        else $error("push into full queue");
    a_first_after_eos: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_end_of_stream) |=> first_reg)
        else $error("stream start not marked after final byte");

endmodule

@@ sv/lzwe_back.sv @@
// Back end of the LZW encoder: dictionary memory, scan engine and code
// output register. Depends on lzwe_pkg and is fed by lzwe_front.
module lzwe_back #(
    parameter int DICT_ENTRIES = lzwe_pkg::DICT_ENTRIES_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lzwe_pkg::lzwe_item_t       q_item,
    input  logic                       q_valid,
    output logic                       q_pop,
    input  logic [lzwe_pkg::CFG_W-1:0] dict_limit,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_last_out
);
    import lzwe_pkg::*;

    localparam int CW = $clog2(DICT_ENTRIES);
    localparam int NW = CW + 1;
    localparam int EW = CW + 8;

    lzwe_state_t   state_reg, state_next;
    lzwe_item_t    cur_reg, cur_next;
    logic [CW-1:0] prefix_reg, prefix_next;
    logic [NW-1:0] next_free_reg, next_free_next;
    logic [NW-1:0] scan_reg, scan_next;
    logic [CW-1:0] code_a_reg, code_a_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_out_byte_reg, m_out_byte_next;
    logic          m_last_out_reg, m_last_out_next;

    logic [EW-1:0] mem [DICT_ENTRIES];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;

    logic [NW-1:0] limit_eff;
    logic [NW-1:0] scan_inc;
    logic          out_free;
    logic          hit;
    logic [15:0]   code_a16;
    logic [15:0]   prefix16;

    assign limit_eff = (32'(dict_limit) > 32'(DICT_ENTRIES)) ? NW'(DICT_ENTRIES)
                                                              : NW'(dict_limit);
    assign scan_inc  = scan_reg + 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign hit       = (rd_data_reg == {prefix_reg, cur_reg.in_byte});
    assign code_a16  = 16'(code_a_reg);
    assign prefix16  = 16'(prefix_reg);
    assign mem_we    = (state_reg == ST_MISS) && (next_free_reg < limit_eff);

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last_out = m_last_out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.first) begin
                        state_next = ST_TAIL;
                    end else if (next_free_reg == NW'(FIRST_FREE)) begin
                        state_next = ST_MISS;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: state_next = ST_CMP;
            ST_CMP: begin
                if (hit) begin
                    state_next = ST_TAIL;
                end else if (scan_inc < next_free_reg) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS: state_next = ST_A_LO;
            ST_A_LO: if (out_free) state_next = ST_A_HI;
            ST_A_HI: if (out_free) state_next = ST_TAIL;
            ST_TAIL: state_next = cur_reg.end_of_stream ? ST_B_LO : ST_IDLE;
            ST_B_LO: if (out_free) state_next = ST_B_HI;
            ST_B_HI: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cur_next        = cur_reg;
        prefix_next     = prefix_reg;
        next_free_next  = next_free_reg;
        scan_next       = scan_reg;
        code_a_next     = code_a_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_out_byte_next = m_out_byte_reg;
        m_last_out_next = m_last_out_reg;
        q_pop           = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    cur_next  = q_item;
                    scan_next = NW'(FIRST_FREE);
                    if (q_item.first) begin
                        prefix_next = CW'(q_item.in_byte);
                    end
                end
            end
            ST_CMP: begin
                if (hit) begin
                    prefix_next = scan_reg[CW-1:0];
                end else begin
                    scan_next = scan_inc;
                end
            end
            ST_MISS: begin
                code_a_next = prefix_reg;
                prefix_next = CW'(cur_reg.in_byte);
                if (mem_we) begin
                    next_free_next = next_free_reg + 1'b1;
                end
            end
            ST_A_LO: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = code_a16[7:0];
                    m_last_out_next = 1'b0;
                end
            end
            ST_A_HI: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = code_a16[15:8];
                    m_last_out_next = 1'b0;
                end
            end
            ST_B_LO: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = prefix16[7:0];
                    m_last_out_next = 1'b0;
                end
            end
            ST_B_HI: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = prefix16[15:8];
                    m_last_out_next = 1'b1;
                    next_free_next  = NW'(FIRST_FREE);
                end
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_free_reg <= NW'(FIRST_FREE);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        prefix_reg     <= prefix_next;
        scan_reg       <= scan_next;
        code_a_reg     <= code_a_next;
        m_out_byte_reg <= m_out_byte_next;
        m_last_out_reg <= m_last_out_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[next_free_reg[CW-1:0]] <= {prefix_reg, cur_reg.in_byte};
        end
        rd_data_reg <= mem[scan_reg[CW-1:0]];
    end

    a_cmp_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> $past(state_reg == ST_READ))
        else $error("compare without a preceding memory read");
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (scan_reg < next_free_reg))
        else $error("scan reads an unwritten dictionary entry");
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(next_free_reg) <= 32'(DICT_ENTRIES))
        else $error("next free code beyond dictionary size");
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B_HI && out_free) |=> (next_free_reg == NW'(FIRST_FREE)))
        else $error("dictionary not emptied at end of stream");

endmodule

@@ sv/lzw_encoder_fixed16.sv @@
// Top level of the LZW encoder with 16-bit output codes.
// Depends on lzwe_pkg, lzwe_front and lzwe_back.
//
// Usage: bytes enter on the s_ channel (s_in_byte, s_end_of_stream marks the
// final byte of a stream); compressed codes leave on the m_ channel as byte
// pairs, low byte first, with m_last_out set on the final byte of a stream.
// The cfg_ channel writes dict_limit, the maximum number of codes, and is
// always ready; it should be written only while the encoder is idle.
// A two-entry queue decouples input acceptance from the dictionary engine.
// The engine scans the dictionary linearly through a single memory read port,
// reading each entry searched (ST_READ) and then comparing it (ST_CMP); the
// search runs over the entries added so far in the stream (at most
// DICT_ENTRIES - 256) and stops at the first match. The first byte of a
// stream needs no search.
// Reset clears the queue, the output register and the dictionary fill count,
// and restores dict_limit to 4096; no clearing pass is needed. When the
// receiver stalls, the output register holds its transaction, the engine
// waits and the queue fills, after which s_ready goes low.
module lzw_encoder_fixed16 #(
    parameter int DICT_ENTRIES = lzwe_pkg::DICT_ENTRIES_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_in_byte,
    input  logic                       s_end_of_stream,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_last_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [lzwe_pkg::CFG_W-1:0] cfg_data
);
    import lzwe_pkg::*;

    logic [CFG_W-1:0] dict_limit_reg;
    lzwe_item_t       q_item;
    logic             q_valid;
    logic             q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dict_limit_reg <= LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            dict_limit_reg <= cfg_data;
        end
    end

    lzwe_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .s_end_of_stream (s_end_of_stream),
        .q_item          (q_item),
        .q_valid         (q_valid),
        .q_pop           (q_pop)
    );

    lzwe_back #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_item     (q_item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .dict_limit (dict_limit_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last_out (m_last_out)
    );

endmodule
